@@ sv/etc_pkg.sv @@
// Package: constants, division selectors and lookup functions for the epoch-to-calendar unit.
`default_nettype none
package etc_pkg;

  // Which constant divisor the shared multiplier is working on
  typedef logic [2:0] div_sel_t;

  localparam div_sel_t DIV_SEC = 3'd0;  // seconds / 60
  localparam div_sel_t DIV_MIN = 3'd1;  // minutes / 60
  localparam div_sel_t DIV_BLK = 3'd2;  // hours / four-year block
  localparam div_sel_t DIV_HR  = 3'd3;  // hours in year / 24
  localparam div_sel_t DIV_WD  = 3'd4;  // day count / 7

  localparam logic [13:0] HOURS_YEAR    = 14'd8760;
  localparam logic [13:0] HOURS_LEAP    = 14'd8784;
  localparam logic [10:0] DAYS_BLOCK    = 11'd1461;
  localparam logic [7:0]  YEAR_BASE     = 8'd70;
  localparam logic [2:0]  WEEKDAY_EPOCH = 3'd4;
  localparam logic [8:0]  LEAP_DAY      = 9'd60;
  localparam logic [4:0]  LEAP_DOM      = 5'd29;
  localparam logic [3:0]  MONTH_FEB     = 4'd1;
  localparam logic [3:0]  MONTH_DEC     = 4'd11;

  // Reciprocal: q ~= (x * div_mul) >> div_shift, never high, at most one low
  function automatic logic [31:0] div_mul(input div_sel_t sel);
    logic [31:0] m;
    case (sel)
      DIV_SEC: m = 32'h8888_8889;
      DIV_MIN: m = 32'h8888_8889;
      DIV_BLK: m = 32'd1959829;
      DIV_HR:  m = 32'd43690;
      DIV_WD:  m = 32'd149796;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] div_shift(input div_sel_t sel);
    logic [5:0] s;
    case (sel)
      DIV_SEC: s = 6'd37;
      DIV_MIN: s = 6'd37;
      DIV_BLK: s = 6'd36;
      DIV_HR:  s = 6'd20;
      DIV_WD:  s = 6'd20;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

  function automatic logic [15:0] div_const(input div_sel_t sel);
    logic [15:0] d;
    case (sel)
      DIV_SEC: d = 16'd60;
      DIV_MIN: d = 16'd60;
      DIV_BLK: d = 16'd35064;
      DIV_HR:  d = 16'd24;
      DIV_WD:  d = 16'd7;
      default: d = 16'd1;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] n;
    case (mon)
      4'd0:    n = 5'd31;
      4'd1:    n = 5'd28;
      4'd2:    n = 5'd31;
      4'd3:    n = 5'd30;
      4'd4:    n = 5'd31;
      4'd5:    n = 5'd30;
      4'd6:    n = 5'd31;
      4'd7:    n = 5'd31;
      4'd8:    n = 5'd30;
      4'd9:    n = 5'd31;
      4'd10:   n = 5'd30;
      4'd11:   n = 5'd31;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

@@ sv/epoch_seconds_to_calendar_unit.sv @@
// Epoch-seconds to broken-down calendar time converter (top level).
//
// Converts an unsigned 32-bit seconds count since 1970-01-01 into second, minute, hour,
// day of month, month, year since 1900, weekday and day of year. Every year divisible by
// four is a leap year, so dates are exact through 2099. One beat is converted at a time:
// a beat is accepted in idle, then converted by five constant divisions on a single
// shared 32x32 multiplier, each an estimate, a back-multiply and a correction, then by
// year stepping and month stepping (none for a leap day) by compare and subtract, and
// the result is loaded into the output register. in_stall_o is high for the whole
// conversion. The result sits in an output register, so the next beat is taken once
// the result has been loaded there; while an earlier result is held by out_stall_i the
// load waits.
`default_nettype none
module epoch_seconds_to_calendar_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [31:0] epoch_seconds_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [5:0]  second_o,
  output      logic [5:0]  minute_o,
  output      logic [4:0]  hour_o,
  output      logic [4:0]  day_of_month_o,
  output      logic [3:0]  month_o,
  output      logic [7:0]  year_since_1900_o,
  output      logic [2:0]  weekday_o,
  output      logic [8:0]  day_of_year_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EST   = 3'd1;
  localparam logic [2:0] ST_BACK  = 3'd2;
  localparam logic [2:0] ST_FIX   = 3'd3;
  localparam logic [2:0] ST_YEAR  = 3'd4;
  localparam logic [2:0] ST_MONTH = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic             out_valid_q, out_valid_d;
  etc_pkg::div_sel_t sel_q;

  logic [31:0] x_q;
  logic [63:0] prod_q;
  logic [31:0] q_q;
  logic [5:0]  sec_q, min_q;
  logic [4:0]  hour_q;
  logic [7:0]  year_q;
  logic [15:0] days_q;
  logic [8:0]  yday_q;
  logic [2:0]  wday_q;
  logic [3:0]  mon_q;
  logic [8:0]  dom_q;

  logic [5:0]  sec_oq, min_oq;
  logic [4:0]  hour_oq, dom_oq;
  logic [3:0]  mon_oq;
  logic [7:0]  year_oq;
  logic [2:0]  wday_oq;
  logic [8:0]  yday_oq;

  // Shared multiplier
  logic [31:0] q_est;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [15:0] dconst;

  // Quotient correction
  logic [31:0] rem_raw, rem_fix, q_fix;
  logic        fix_up;

  logic        leap;
  logic [13:0] span;
  logic [8:0]  d1;
  logic [4:0]  mlen;
  logic        load_out;

  assign dconst = etc_pkg::div_const(sel_q);
  assign q_est  = 32'(prod_q >> etc_pkg::div_shift(sel_q));
  assign mul_a  = (state_q == ST_BACK) ? q_est : x_q;
  assign mul_b  = (state_q == ST_BACK) ? {16'd0, dconst} : etc_pkg::div_mul(sel_q);
  assign mul_p  = 64'(mul_a) * 64'(mul_b);

  assign rem_raw = x_q - prod_q[31:0];
  assign fix_up  = rem_raw >= {16'd0, dconst};
  assign rem_fix = fix_up ? rem_raw - {16'd0, dconst} : rem_raw;
  assign q_fix   = fix_up ? q_q + 32'd1 : q_q;

  assign leap = (year_q[1:0] == 2'b00);
  assign span = leap ? etc_pkg::HOURS_LEAP : etc_pkg::HOURS_YEAR;
  assign d1   = yday_q + 9'd1;
  assign mlen = etc_pkg::month_len(mon_q);

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_EST;
      ST_EST:   state_d = ST_BACK;
      ST_BACK:  state_d = ST_FIX;
      ST_FIX: begin
        case (sel_q)
          etc_pkg::DIV_BLK: state_d = ST_YEAR;
          etc_pkg::DIV_WD: begin
            if (leap && d1 == etc_pkg::LEAP_DAY) state_d = ST_DONE;
            else                                  state_d = ST_MONTH;
          end
          default: state_d = ST_EST;
        endcase
      end
      ST_YEAR:  if (x_q < 32'(span)) state_d = ST_EST;
      ST_MONTH: begin
        if (!(mon_q < etc_pkg::MONTH_DEC && 9'(mlen) < dom_q)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        x_q   <= epoch_seconds_i;
        sel_q <= etc_pkg::DIV_SEC;
      end
      ST_EST: prod_q <= mul_p;
      ST_BACK: begin
        q_q    <= q_est;
        prod_q <= mul_p;
      end
      ST_FIX: begin
        case (sel_q)
          etc_pkg::DIV_SEC: begin
            sec_q <= rem_fix[5:0];
            x_q   <= q_fix;
            sel_q <= etc_pkg::DIV_MIN;
          end
          etc_pkg::DIV_MIN: begin
            min_q <= rem_fix[5:0];
            x_q   <= q_fix;
            sel_q <= etc_pkg::DIV_BLK;
          end
          etc_pkg::DIV_BLK: begin
            year_q <= {q_fix[5:0], 2'b00} + etc_pkg::YEAR_BASE;
            days_q <= 16'(q_fix[5:0]) * 16'(etc_pkg::DAYS_BLOCK);
            x_q    <= rem_fix;
            sel_q  <= etc_pkg::DIV_HR;
          end
          etc_pkg::DIV_HR: begin
            hour_q <= rem_fix[4:0];
            yday_q <= q_fix[8:0];
            x_q    <= 32'(days_q + {7'd0, q_fix[8:0]} + 16'(etc_pkg::WEEKDAY_EPOCH));
            sel_q  <= etc_pkg::DIV_WD;
          end
          etc_pkg::DIV_WD: begin
            wday_q <= rem_fix[2:0];
            if (leap && d1 == etc_pkg::LEAP_DAY) begin
              mon_q <= etc_pkg::MONTH_FEB;
              dom_q <= 9'(etc_pkg::LEAP_DOM);
            end else begin
              mon_q <= 4'd0;
              dom_q <= (leap && d1 > etc_pkg::LEAP_DAY) ? d1 - 9'd1 : d1;
            end
          end
          default: sel_q <= etc_pkg::DIV_SEC;
        endcase
      end
      ST_YEAR: begin
        // hours left in the block; step over whole years
        if (x_q >= 32'(span)) begin
          x_q    <= x_q - 32'(span);
          days_q <= days_q + (leap ? 16'd366 : 16'd365);
          year_q <= year_q + 8'd1;
        end
      end
      ST_MONTH: begin
        if (mon_q < etc_pkg::MONTH_DEC && 9'(mlen) < dom_q) begin
          dom_q <= dom_q - 9'(mlen);
          mon_q <= mon_q + 4'd1;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      sec_oq  <= sec_q;
      min_oq  <= min_q;
      hour_oq <= hour_q;
      dom_oq  <= dom_q[4:0];
      mon_oq  <= mon_q;
      year_oq <= year_q;
      wday_oq <= wday_q;
      yday_oq <= yday_q;
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign second_o          = sec_oq;
  assign minute_o          = min_oq;
  assign hour_o            = hour_oq;
  assign day_of_month_o    = dom_oq;
  assign month_o           = mon_oq;
  assign year_since_1900_o = year_oq;
  assign weekday_o         = wday_oq;
  assign day_of_year_o     = yday_oq;

endmodule
`default_nettype wire

@@ sim/calendar_checker.sv @@
// Checker: predicts the calendar fields of each accepted beat and compares results in order.
module calendar_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] epoch_seconds_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [5:0]  second_i,
  input  logic [5:0]  minute_i,
  input  logic [4:0]  hour_i,
  input  logic [4:0]  day_of_month_i,
  input  logic [3:0]  month_i,
  input  logic [7:0]  year_since_1900_i,
  input  logic [2:0]  weekday_i,
  input  logic [8:0]  day_of_year_i,
  output int          mismatches_o,
  output int          pending_o
);

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] mday;
    logic [3:0] month;
    logic [7:0] year;
    logic [2:0] weekday;
    logic [8:0] yday;
  } calendar_t;

  localparam logic [31:0] HOURS_PER_BLOCK = 32'd35064;
  localparam logic [31:0] HOURS_PER_YEAR  = 32'd8760;
  localparam logic [31:0] DAYS_PER_BLOCK  = 32'd1461;
  localparam logic [31:0] EPOCH_YEAR      = 32'd70;
  localparam logic [31:0] EPOCH_WEEKDAY   = 32'd4;
  localparam logic [31:0] LEAP_DAY_NUM    = 32'd60;
  // month lengths, January in the low five bits
  localparam logic [59:0] MONTH_DAYS = {5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
                                        5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31};

  calendar_t expected_q[$];
  int        fail_count = 0;

  function automatic calendar_t to_calendar(input logic [31:0] secs);
    calendar_t   c;
    logic [31:0] t, r, year, days, span, yday, d, mon;
    logic        found, leap;
    t = secs;
    r = t % 60;
    c.second = r[5:0];
    t = t / 60;
    r = t % 60;
    c.minute = r[5:0];
    t = t / 60;
    year = (t / HOURS_PER_BLOCK) * 4 + EPOCH_YEAR;
    days = (t / HOURS_PER_BLOCK) * DAYS_PER_BLOCK;
    t = t % HOURS_PER_BLOCK;
    // walk the years of the four-year block, every fourth one leap
    found = 1'b0;
    for (int k = 0; k < 4; k++) begin
      span = (year[1:0] == 2'b00) ? HOURS_PER_YEAR + 24 : HOURS_PER_YEAR;
      if (!found && t >= span) begin
        days = days + span / 24;
        year = year + 1;
        t = t - span;
      end else begin
        found = 1'b1;
      end
    end
    r = t % 24;
    c.hour = r[4:0];
    yday = t / 24;
    r = (days + yday + EPOCH_WEEKDAY) % 7;
    c.weekday = r[2:0];
    c.yday = yday[8:0];
    c.year = year[7:0];
    leap = (year[1:0] == 2'b00);
    d = yday + 1;
    mon = 0;
    if (leap && d == LEAP_DAY_NUM) begin
      mon = 1;
      d = 29;
    end else begin
      if (leap && d > LEAP_DAY_NUM) d = d - 1;
      while (mon < 11 && {27'd0, MONTH_DAYS[mon*5 +: 5]} < d) begin
        d = d - {27'd0, MONTH_DAYS[mon*5 +: 5]};
        mon = mon + 1;
      end
    end
    c.mday = d[4:0];
    c.month = mon[3:0];
    return c;
  endfunction

  task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    calendar_t got, want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) expected_q.push_back(to_calendar(epoch_seconds_i));
      if (out_valid_i && !out_stall_i) begin
        got = {second_i, minute_i, hour_i, day_of_month_i, month_i, year_since_1900_i,
               weekday_i, day_of_year_i};
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %h", $time, got);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("second", {3'd0, want.second}, {3'd0, got.second});
          check_field("minute", {3'd0, want.minute}, {3'd0, got.minute});
          check_field("hour", {4'd0, want.hour}, {4'd0, got.hour});
          check_field("day_of_month", {4'd0, want.mday}, {4'd0, got.mday});
          check_field("month", {5'd0, want.month}, {5'd0, got.month});
          check_field("year_since_1900", {1'b0, want.year}, {1'b0, got.year});
          check_field("weekday", {6'd0, want.weekday}, {6'd0, got.weekday});
          check_field("day_of_year", want.yday, got.yday);
        end
      end
      mismatches_o <= fail_count;
      pending_o    <= expected_q.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench top: drives epoch-second beats and result stalls, and gives the verdict.
module tb_top;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int BEATS_PER_PHASE  = 490;
  localparam int SETTLE_CYCLES    = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [31:0] epoch_seconds = 32'd0;
  logic        out_stall = 1'b0;
  logic        in_stall, out_valid;
  logic [5:0]  second, minute;
  logic [4:0]  hour, day_of_month;
  logic [3:0]  month;
  logic [7:0]  year_since_1900;
  logic [2:0]  weekday;
  logic [8:0]  day_of_year;
  int          mismatches, pending;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          cycles = 0;

  epoch_seconds_to_calendar_unit u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .epoch_seconds_i   (epoch_seconds),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .second_o          (second),
    .minute_o          (minute),
    .hour_o            (hour),
    .day_of_month_o    (day_of_month),
    .month_o           (month),
    .year_since_1900_o (year_since_1900),
    .weekday_o         (weekday),
    .day_of_year_o     (day_of_year)
  );

  calendar_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .epoch_seconds_i   (epoch_seconds),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .second_i          (second),
    .minute_i          (minute),
    .hour_i            (hour),
    .day_of_month_i    (day_of_month),
    .month_i           (month),
    .year_since_1900_i (year_since_1900),
    .weekday_i         (weekday),
    .day_of_year_i     (day_of_year),
    .mismatches_o      (mismatches),
    .pending_o         (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // one beat: optional idle cycles, then hold until accepted; returns at a falling edge
  task automatic send_beat(input logic [31:0] secs);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    epoch_seconds <= secs;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] corners [22];
    logic [31:0] secs;
    logic [63:0] wide;
    corners = '{32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                32'd68083200,   // 28 Feb 1972
                32'd68169600,   // leap day 1972
                32'd68256000,   // 1 Mar 1972
                32'd94694399, 32'd94694400,     // across the end of a leap year
                32'd126230399, 32'd126230400,   // across a four-year block
                32'd2147483647, 32'd2147483648,
                32'd4102444800, // 1 Jan 2100
                32'd4107542400, // 2100 still leap under the every-fourth-year rule
                32'd4133980800, // day 366 of 2100
                32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (corners[i]) send_beat(corners[i]);
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 54; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        case ($urandom_range(3))
          0: secs = $urandom();
          1: begin
            // midnight or the last second of a random day
            wide = 64'($urandom_range(49709));
            wide = wide * 86400 + ($urandom_range(1) ? 64'd86399 : 64'd0);
            secs = wide[31:0];
          end
          2: secs = $urandom_range(32'hFFFF_FFFF, 32'd4102444800);
          default: secs = $urandom_range(32'd126230400);
        endcase
        send_beat(secs);
        if (n == BEATS_PER_PHASE / 2) drain();
      end
      drain();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
